// File: design/plcc_pkg.sv
`timescale 1ns / 1ps

package plcc_pkg;

    localparam int unsigned MAX_VARIANTS = 10;
    localparam int unsigned VAR_W        = 4;
    localparam int unsigned WGT_W        = 4;
    localparam int unsigned DBL_W        = 10;
    localparam int unsigned ADD_OUT_W    = 32;
    localparam int unsigned N_IN_W       = 32;
    localparam int unsigned STEP_W       = 10;
    localparam int unsigned CNT_A_W      = 12;
    localparam int unsigned SUM3_W       = 7;
    localparam int unsigned CFG_IDX_W    = 1;

    localparam logic [STEP_W-1:0] MAX_STEPS      = 10'd1022;
    localparam logic [WGT_W-1:0]  ADD_WEIGHT_RST = 4'd6;
    localparam logic [WGT_W-1:0]  DBL_WEIGHT_RST = 4'd5;
    localparam logic [63:0]       DEC_DEN        = 64'd100000000000000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADD_WEIGHT = 1'b0,
        CFG_DBL_WEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SETUP,
        ST_STEP,
        ST_DIV,
        ST_CMP,
        ST_FINAL
    } t_state;

    typedef enum logic [3:0] {
        RULE_TRIPLE,
        RULE_HALF_DIFF6,
        RULE_SUB,
        RULE_HALF_SUM,
        RULE_HALF_D,
        RULE_THIRD_D,
        RULE_THIRD_SUM,
        RULE_THIRD_DIFF,
        RULE_HALF_E
    } t_rule;

    typedef struct packed {
        logic load_n;
        logic mul_step;
        logic setup;
        logic step;
        logic div_apply;
        logic cmp;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_last;
        logic degen;
        logic stop;
        logic need_div;
        logic div_busy;
        logic last_var;
        logic out_free;
    } t_dp_sts;

    // decimal fraction over 10^17 to q0.64, round to nearest
    function automatic logic [63:0] to_q64(input logic [63:0] num);
        logic [63:0] rem;
        logic [63:0] q;
        rem = num;
        q   = '0;
        for (int i = 0; i < 64; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= DEC_DEN) begin
                rem  = rem - DEC_DEN;
                q[0] = 1'b1;
            end
        end
        rem = rem << 1;
        if (rem >= DEC_DEN) begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    localparam logic [63:0] RATIO_Q64 [MAX_VARIANTS] = '{
        to_q64(64'd61803398874989485), to_q64(64'd72360679774997897),
        to_q64(64'd58017872829546410), to_q64(64'd63283980608870629),
        to_q64(64'd61242994950949500), to_q64(64'd62018198080741576),
        to_q64(64'd61721461653440386), to_q64(64'd61834711965622806),
        to_q64(64'd61791440652881789), to_q64(64'd61807966846989581)
    };

    // one radix-256 digit of a divide by three: {remainder, quotient digit}
    function automatic logic [9:0] div3_step(input logic [1:0] rem, input logic [7:0] chunk);
        logic [9:0]  v;
        logic [19:0] p;
        logic [7:0]  q;
        logic [9:0]  back;
        v    = {rem, chunk};
        p    = 20'(v) * 20'd683;
        q    = p[18:11];
        back = 10'(q) * 10'd3;
        return {2'(v - back), q};
    endfunction

    // remainder by three of a small value
    function automatic logic [1:0] mod3_small(input logic [SUM3_W-1:0] x);
        logic [14:0]       p;
        logic [5:0]        q;
        logic [SUM3_W-1:0] back;
        p    = 15'(x) * 15'd171;
        q    = p[14:9];
        back = SUM3_W'(q) * SUM3_W'(3);
        return 2'(x - back);
    endfunction

    function automatic logic [1:0] red3(input logic [2:0] x);
        return (x >= 3'd3) ? 2'(x - 3'd3) : 2'(x);
    endfunction

endpackage

// File: design/plcc_div3.sv
`timescale 1ns / 1ps

module plcc_div3 import plcc_pkg::*; #(
    parameter int unsigned X_W = 33
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [X_W-1:0] i_x,
    output logic           o_busy,
    output logic [X_W-1:0] o_q
);

    localparam int unsigned CH    = (X_W + 7) / 8;
    localparam int unsigned SR_W  = CH * 8;
    localparam int unsigned CNT_W = $clog2(CH + 1);

    logic [SR_W-1:0]  r_sr;
    logic [1:0]       r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [9:0]       digit;

    assign digit  = div3_step(r_rem, r_sr[SR_W-1 -: 8]);
    assign o_busy = r_busy;
    assign o_q    = r_sr[X_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(CH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient digits shift in from the bottom as dividend digits leave the top
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sr  <= SR_W'(i_x);
            r_rem <= '0;
        end else if (r_busy) begin
            r_sr  <= {r_sr[SR_W-9:0], digit[7:0]};
            r_rem <= digit[9:8];
        end
    end

endmodule

// File: design/plcc_dp.sv
`timescale 1ns / 1ps

module plcc_dp import plcc_pkg::*; #(
    parameter int unsigned N_BITS   = 32,
    parameter int unsigned VARIANTS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WGT_W-1:0]     i_cfg_data,
    input  logic [N_IN_W-1:0]    i_n_value,
    input  logic                 i_out_stall,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_out_valid,
    output logic [DBL_W-1:0]     o_doublings,
    output logic [ADD_OUT_W-1:0] o_additions
);

    localparam int unsigned W      = N_BITS;
    localparam int unsigned A_W    = (W > CNT_A_W) ? W : CNT_A_W;
    localparam int unsigned COST_W = A_W + WGT_W + 1;
    localparam int unsigned ND     = (W + 1) / 2;
    localparam int unsigned ACC_W  = W + 64;
    localparam logic [ACC_W-1:0] ACC_HALF = {{W{1'b0}}, 1'b1, 63'd0};

    logic [WGT_W-1:0]  r_add_weight;
    logic [WGT_W-1:0]  r_dbl_weight;
    logic [W-1:0]      r_n;
    logic [VAR_W-1:0]  r_var;
    logic [ACC_W-1:0]  r_acc;
    logic [1:0]        r_k;
    logic [W-1:0]      r_d;
    logic [W-1:0]      r_e;
    logic [DBL_W-1:0]  r_nd;
    logic [A_W-1:0]    r_na;
    logic [STEP_W-1:0] r_steps;
    t_rule             r_rule;
    logic              r_have;
    logic [COST_W-1:0] r_best;
    logic [DBL_W-1:0]  r_best_dbl;
    logic [A_W-1:0]    r_best_add;
    logic              r_out_valid;
    logic [DBL_W-1:0]  r_out_dbl;
    logic [ADD_OUT_W-1:0] r_out_add;

    logic [15:0]       q_slice;
    logic [W+15:0]     prod;
    logic [ACC_W-1:0]  acc_next;
    logic [W-1:0]      round_val;
    logic [W:0]        two_r;
    logic [W-1:0]      d_init;
    logic [W-1:0]      e_init;
    logic              degen;

    logic              d_lt;
    logic [W-1:0]      dd;
    logic [W-1:0]      ee;
    logic [1:0]        dm_raw;
    logic [1:0]        em_raw;
    logic [1:0]        dm;
    logic [1:0]        em;
    logic [1:0]        sum_m3;
    logic [1:0]        diff_m3;
    logic [W-1:0]      diff;
    logic              near;
    logic [W:0]        dp3;
    logic              big;
    t_rule             rule;
    logic              need_div;
    logic [W:0]        div_x;
    logic [W:0]        div_q_full;
    logic [W-1:0]      div_q;
    logic              div_busy;
    logic [W-1:0]      d_new;
    logic [W-1:0]      e_new;
    logic [1:0]        add_inc;
    logic              dbl_inc;
    logic [COST_W-1:0] cost;

    function automatic logic [1:0] mod3(input logic [W-1:0] v);
        logic [2*ND-1:0]   vp;
        logic [SUM3_W-1:0] s;
        vp = (2*ND)'(v);
        s  = '0;
        for (int i = 0; i < ND; i++) begin
            s = s + SUM3_W'(vp[2*i +: 2]);
        end
        return mod3_small(s);
    endfunction

    // round(n * ratio) from four 16-bit slices of the ratio
    assign q_slice   = RATIO_Q64[r_var][{r_k, 4'b0} +: 16];
    assign prod      = (W+16)'(r_n) * (W+16)'(q_slice);
    assign acc_next  = r_acc + (ACC_W'(prod) << {r_k, 4'b0});
    assign round_val = r_acc[ACC_W-1:64];
    assign degen     = (round_val >= r_n);
    assign two_r     = {round_val, 1'b0};
    assign d_init    = r_n - round_val;
    assign e_init    = W'(two_r - (W+1)'(r_n));

    // rule selection on the ordered pair
    assign d_lt    = (r_d < r_e);
    assign dd      = d_lt ? r_e : r_d;
    assign ee      = d_lt ? r_d : r_e;
    assign dm_raw  = mod3(r_d);
    assign em_raw  = mod3(r_e);
    assign dm      = d_lt ? em_raw : dm_raw;
    assign em      = d_lt ? dm_raw : em_raw;
    assign sum_m3  = red3(3'(dm) + 3'(em));
    assign diff_m3 = red3(3'(dm) + 3'd3 - 3'(em));
    assign diff    = dd - ee;
    assign near    = (diff <= (ee >> 2));
    assign dp3     = (W+1)'(dd) + (W+1)'(3);
    assign big     = ((dp3 >> 2) <= (W+1)'(ee));

    always_comb begin
        priority if (near && sum_m3 == 2'd0) begin
            rule = RULE_TRIPLE;
        end else if (near && !diff[0] && diff_m3 == 2'd0) begin
            rule = RULE_HALF_DIFF6;
        end else if (big) begin
            rule = RULE_SUB;
        end else if (dd[0] == ee[0]) begin
            rule = RULE_HALF_SUM;
        end else if (!dd[0]) begin
            rule = RULE_HALF_D;
        end else if (dm == 2'd0) begin
            rule = RULE_THIRD_D;
        end else if (sum_m3 == 2'd0) begin
            rule = RULE_THIRD_SUM;
        end else if (diff_m3 == 2'd0) begin
            rule = RULE_THIRD_DIFF;
        end else begin
            rule = RULE_HALF_E;
        end
    end

    always_comb begin
        need_div = 1'b0;
        div_x    = '0;
        d_new    = dd;
        e_new    = ee;
        add_inc  = 2'd1;
        dbl_inc  = 1'b1;
        unique case (rule)
            RULE_TRIPLE: begin
                need_div = 1'b1;
                div_x    = ((W+1)'(dd) << 1) - (W+1)'(ee);
                add_inc  = 2'd3;
                dbl_inc  = 1'b0;
            end
            RULE_HALF_DIFF6: d_new = diff >> 1;
            RULE_SUB: begin
                d_new   = diff;
                dbl_inc = 1'b0;
            end
            RULE_HALF_SUM: d_new = diff >> 1;
            RULE_HALF_D:   d_new = dd >> 1;
            RULE_THIRD_D: begin
                need_div = 1'b1;
                div_x    = (W+1)'(dd);
                add_inc  = 2'd3;
            end
            RULE_THIRD_SUM: begin
                need_div = 1'b1;
                div_x    = (W+1)'(dd) - ((W+1)'(ee) << 1);
                add_inc  = 2'd3;
            end
            RULE_THIRD_DIFF: begin
                need_div = 1'b1;
                div_x    = (W+1)'(diff);
                add_inc  = 2'd3;
            end
            RULE_HALF_E: e_new = ee >> 1;
            default: begin
                need_div = 1'b0;
            end
        endcase
    end

    plcc_div3 #(
        .X_W(W + 1)
    ) u_div3 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.step && need_div),
        .i_x    (div_x),
        .o_busy (div_busy),
        .o_q    (div_q_full)
    );

    assign div_q = div_q_full[W-1:0];

    assign cost = COST_W'(r_add_weight) * COST_W'(r_na)
                + COST_W'(r_dbl_weight) * COST_W'(r_nd);

    assign o_sts.mul_last = (r_k == 2'd3);
    assign o_sts.degen    = degen;
    assign o_sts.stop     = (r_d == r_e) || (r_steps == MAX_STEPS) || (ee == '0);
    assign o_sts.need_div = need_div;
    assign o_sts.div_busy = div_busy;
    assign o_sts.last_var = (r_var == VAR_W'(VARIANTS - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_doublings = r_out_dbl;
    assign o_additions = r_out_add;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_weight <= ADD_WEIGHT_RST;
            r_dbl_weight <= DBL_WEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ADD_WEIGHT: r_add_weight <= i_cfg_data;
                CFG_DBL_WEIGHT: r_dbl_weight <= i_cfg_data;
                default: r_add_weight <= r_add_weight;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_have      <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_n) begin
                r_have <= 1'b0;
            end else if (i_cmd.cmp) begin
                r_have <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_n) begin
            r_n   <= W'(i_n_value);
            r_var <= '0;
            r_acc <= ACC_HALF;
            r_k   <= '0;
        end
        if (i_cmd.mul_step) begin
            r_acc <= acc_next;
            r_k   <= r_k + 2'd1;
        end
        if (i_cmd.setup) begin
            r_steps <= '0;
            if (degen) begin
                r_nd <= '0;
                r_na <= A_W'(r_n);
            end else begin
                r_d  <= d_init;
                r_e  <= e_init;
                r_nd <= DBL_W'(1);
                r_na <= A_W'(1);
            end
        end
        if (i_cmd.step) begin
            r_d     <= d_new;
            r_e     <= e_new;
            r_rule  <= rule;
            r_nd    <= r_nd + DBL_W'(dbl_inc);
            r_na    <= r_na + A_W'(add_inc);
            r_steps <= r_steps + STEP_W'(1);
        end
        if (i_cmd.div_apply) begin
            unique case (r_rule)
                RULE_TRIPLE: begin
                    r_d <= div_q;
                    r_e <= (r_e - div_q) >> 1;
                end
                RULE_THIRD_D: r_d <= div_q - r_e;
                default:      r_d <= div_q;
            endcase
        end
        if (i_cmd.cmp) begin
            if (!r_have || cost < r_best) begin
                r_best     <= cost;
                r_best_dbl <= r_nd;
                r_best_add <= r_na;
            end
            r_var <= r_var + VAR_W'(1);
            r_acc <= ACC_HALF;
            r_k   <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_dbl <= r_best_dbl;
            r_out_add <= ADD_OUT_W'(r_best_add);
        end
    end

endmodule

// File: design/plcc_ctrl.sv
`timescale 1ns / 1ps

module plcc_ctrl import plcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_n = 1'b1;
                    n_state      = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.mul_last) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_sts.degen ? ST_CMP : ST_STEP;
            end
            ST_STEP: begin
                if (i_sts.stop) begin
                    n_state = ST_CMP;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.need_div) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_apply = 1'b1;
                    n_state         = ST_STEP;
                end
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_sts.last_var ? ST_FINAL : ST_MUL;
            end
            ST_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: design/prac_lucas_chain_cost.sv
`timescale 1ns / 1ps
// one item at a time; per ratio variant: the 64-bit ratio multiply in four 16-bit slices, setup,
// the reduction rules, where a divide-by-three rule waits on the radix-256 divider before its
// result is applied, then the stop check and the cost compare
// next item accepted as soon as the result sits in the output register
// synchronous active-low reset: idle, output empty, weights back to 6 and 5
module prac_lucas_chain_cost import plcc_pkg::*; #(
    parameter int unsigned N_BITS   = 32,
    parameter int unsigned VARIANTS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WGT_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [N_IN_W-1:0]    i_n_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DBL_W-1:0]     o_doublings,
    output logic [ADD_OUT_W-1:0] o_additions
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    plcc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    plcc_dp #(
        .N_BITS  (N_BITS),
        .VARIANTS(VARIANTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_n_value  (i_n_value),
        .i_out_stall(i_out_stall),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .o_doublings(o_doublings),
        .o_additions(o_additions)
    );

endmodule

// File: tb/prac_lucas_chain_cost_tb.sv
`timescale 1ns / 1ps

module prac_lucas_chain_cost_tb;
    import plcc_pkg::*;

    localparam int unsigned RATIO_COUNT    = 10;
    localparam int unsigned CHAIN_STEP_CAP = 1022;
    localparam int unsigned STALL_LIMIT    = 40000;
    localparam int unsigned SETTLE_CYCLES  = 1500;
    localparam logic [127:0] DEC_SCALE     = 128'd100000000000000000;

    typedef struct packed {
        logic [DBL_W-1:0]     dbl;
        logic [ADD_OUT_W-1:0] adds;
    } t_chain_cost;

    class lucas_cost_board;
        logic [63:0]      golden_q64 [RATIO_COUNT];
        logic [WGT_W-1:0] add_w;
        logic [WGT_W-1:0] dbl_w;
        t_chain_cost      expected_costs [$];
        int unsigned      errors;

        function new();
            logic [63:0]  dec [RATIO_COUNT];
            logic [127:0] scaled;
            dec = '{64'd61803398874989485, 64'd72360679774997897, 64'd58017872829546410,
                    64'd63283980608870629, 64'd61242994950949500, 64'd62018198080741576,
                    64'd61721461653440386, 64'd61834711965622806, 64'd61791440652881789,
                    64'd61807966846989581};
            for (int i = 0; i < RATIO_COUNT; i++) begin
                scaled = (128'(dec[i]) << 64) + (DEC_SCALE >> 1);
                golden_q64[i] = 64'(scaled / DEC_SCALE);
            end
            add_w  = ADD_WEIGHT_RST;
            dbl_w  = DBL_WEIGHT_RST;
            errors = 0;
        endfunction

        function void set_weight(input t_cfg_idx idx, input logic [WGT_W-1:0] val);
            case (idx)
                CFG_ADD_WEIGHT: add_w = val;
                CFG_DBL_WEIGHT: dbl_w = val;
                default: ;
            endcase
        endfunction

        // prac reduction for one ratio
        function void run_chain(input logic [63:0] n, input logic [63:0] q,
                                output logic [63:0] dbl, output logic [63:0] adds);
            logic [127:0] prod;
            logic [63:0]  r;
            logic [63:0]  d;
            logic [63:0]  e;
            logic [63:0]  t;
            int unsigned  steps;
            prod  = 128'(n) * 128'(q) + (128'd1 << 63);
            r     = prod[127:64];
            dbl   = 64'd1;
            adds  = 64'd1;
            steps = 0;
            if (r >= n) begin
                dbl  = 64'd0;
                adds = n;
                return;
            end
            d = n - r;
            e = 64'(2 * r) - n;
            while (d != e && steps < CHAIN_STEP_CAP) begin
                if (d < e) begin
                    t = d;
                    d = e;
                    e = t;
                end
                if (e == 0 || d == 0) break;
                steps++;
                if (d - e <= e / 4 && 64'(d + e) % 3 == 0) begin
                    d = 64'(64'(2 * d) - e) / 3;
                    e = (e - d) / 2;
                    adds += 3;
                end else if (d - e <= e / 4 && (d - e) % 6 == 0) begin
                    d = (d - e) / 2;
                    adds += 1;
                    dbl  += 1;
                end else if (64'(d + 3) / 4 <= e) begin
                    d = d - e;
                    adds += 1;
                end else if (64'(d + e) % 2 == 0) begin
                    d = (d - e) / 2;
                    adds += 1;
                    dbl  += 1;
                end else if (d % 2 == 0) begin
                    d = d / 2;
                    adds += 1;
                    dbl  += 1;
                end else if (d % 3 == 0) begin
                    d = d / 3 - e;
                    adds += 3;
                    dbl  += 1;
                end else if (64'(d + e) % 3 == 0) begin
                    d = 64'(d - 64'(2 * e)) / 3;
                    adds += 3;
                    dbl  += 1;
                end else if ((d - e) % 3 == 0) begin
                    d = (d - e) / 3;
                    adds += 3;
                    dbl  += 1;
                end else begin
                    e = e / 2;
                    adds += 1;
                    dbl  += 1;
                end
            end
        endfunction

        function t_chain_cost cheapest_chain(input logic [N_IN_W-1:0] n);
            logic [63:0] dbl;
            logic [63:0] adds;
            logic [63:0] cost;
            logic [63:0] best_cost;
            logic [63:0] best_dbl;
            logic [63:0] best_adds;
            t_chain_cost res;
            best_cost = '0;
            best_dbl  = '0;
            best_adds = '0;
            for (int i = 0; i < RATIO_COUNT; i++) begin
                run_chain(64'(n), golden_q64[i], dbl, adds);
                cost = 64'(add_w) * adds + 64'(dbl_w) * dbl;
                if (i == 0 || cost < best_cost) begin
                    best_cost = cost;
                    best_dbl  = dbl;
                    best_adds = adds;
                end
            end
            res.dbl  = (best_dbl > 64'd1023) ? 10'd1023 : best_dbl[DBL_W-1:0];
            res.adds = best_adds[ADD_OUT_W-1:0];
            return res;
        endfunction

        function void note_n(input logic [N_IN_W-1:0] n);
            expected_costs.insert(expected_costs.size(), cheapest_chain(n));
        endfunction

        function void check_result(input logic [DBL_W-1:0] dbl,
                                   input logic [ADD_OUT_W-1:0] adds);
            t_chain_cost exp_cost;
            if (expected_costs.size() == 0) begin
                $display("%0t: unexpected result doublings=%0d additions=%0d",
                         $time, dbl, adds);
                errors++;
                return;
            end
            exp_cost = expected_costs.pop_front();
            if (dbl !== exp_cost.dbl) begin
                $display("%0t: doublings mismatch expected %0d actual %0d",
                         $time, exp_cost.dbl, dbl);
                errors++;
            end
            if (adds !== exp_cost.adds) begin
                $display("%0t: additions mismatch expected %0d actual %0d",
                         $time, exp_cost.adds, adds);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_ADD_WEIGHT;
    logic [WGT_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [N_IN_W-1:0]    i_n_value   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [DBL_W-1:0]     o_doublings;
    logic [ADD_OUT_W-1:0] o_additions;

    lucas_cost_board board = new();
    logic        calm        = 1'b0;
    int unsigned idle_cycles = 0;

    prac_lucas_chain_cost dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_n_value   (i_n_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_doublings (o_doublings),
        .o_additions (o_additions)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 36);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.note_n(i_n_value);
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_result(o_doublings, o_additions);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_n(input logic [N_IN_W-1:0] n);
        if (!calm && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while (!calm && $urandom_range(0, 99) < 36) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_n_value  <= n;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (board.expected_costs.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_weights(input logic [WGT_W-1:0] add_val,
                               input logic [WGT_W-1:0] dbl_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ADD_WEIGHT;
        i_cfg_data <= add_val;
        board.set_weight(CFG_ADD_WEIGHT, add_val);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_DBL_WEIGHT;
        i_cfg_data <= dbl_val;
        board.set_weight(CFG_DBL_WEIGHT, dbl_val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [N_IN_W-1:0] pick_n();
        logic [N_IN_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 64);
            1, 2:    v = $urandom_range(5, 5000);
            3, 4:    v = v >> $urandom_range(0, 31);
            default: ;
        endcase
        return v;
    endfunction

    task automatic random_burst(input int unsigned count, input int unsigned calm_from,
                                input int unsigned calm_to);
        for (int unsigned k = 0; k < count; k++) begin
            calm = (k >= calm_from && k < calm_to);
            send_n(pick_n());
            if ($urandom_range(0, 59) == 0) begin
                wait_results_done();
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        logic [N_IN_W-1:0] directed [$];
        directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd11,
                     32'd101, 32'd1009, 32'd65537, 32'd999983, 32'd2147483647,
                     32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'd4294967291, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) begin
            send_n(directed[k]);
        end
        random_burst(150, 40, 110);

        // weight sweep, ties everywhere at zero weights
        wait_results_done();
        set_weights(4'd0, 4'd0);
        send_n(32'd5);
        send_n(32'hFFFF_FFFF);
        random_burst(140, 0, 0);
        wait_results_done();
        set_weights(4'd15, 4'd15);
        random_burst(140, 0, 0);
        wait_results_done();
        set_weights(4'd15, 4'd0);
        random_burst(140, 0, 0);
        wait_results_done();
        set_weights(4'd0, 4'd15);
        random_burst(140, 0, 0);
        wait_results_done();
        set_weights(4'd1, 4'd1);
        random_burst(140, 0, 0);
        wait_results_done();
        set_weights(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        random_burst(140, 0, 0);

        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.expected_costs.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/plcc_pkg.sv
design/plcc_div3.sv
design/plcc_dp.sv
design/plcc_ctrl.sv
design/prac_lucas_chain_cost.sv
tb/prac_lucas_chain_cost_tb.sv
